FILE: hw/rtl/icph_pkg.sv
// ----------------------------------------------------------------------------
// icph_pkg
// Shared types, codes and helpers for the Internet checksum block with the
// TCP/UDP pseudo-header.
// ----------------------------------------------------------------------------
package icph_pkg;

  localparam int WordW    = 16;
  localparam int KindW    = 3;
  localparam int AddrW    = 32;
  localparam int PosW     = 4;
  localparam int SumW     = WordW + 3;
  localparam int InDataW  = 80;
  localparam int InUserW  = 4;
  localparam int OutDataW = 16;

  typedef logic [KindW-1:0] kind_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [PosW-1:0]  pos_t;

  localparam kind_t KIND_IPV4 = 3'd0;
  localparam kind_t KIND_ICMP = 3'd1;
  localparam kind_t KIND_IGMP = 3'd2;
  localparam kind_t KIND_TCP  = 3'd3;
  localparam kind_t KIND_UDP  = 3'd4;

  localparam word_t PROTO_TCP = 16'd6;
  localparam word_t PROTO_UDP = 16'd17;
  localparam word_t MASK16    = 16'hffff;
  localparam pos_t  POS_MAX   = 4'd15;

  typedef struct packed {
    logic             hit;
    logic [PosW-1:0]  pos;
  } zero_pos_t;

  function automatic zero_pos_t zero_position(input kind_t kind);
    zero_pos_t zp;
    zp.hit = 1'b1;
    case (kind)
      KIND_IPV4: zp.pos = 4'd5;
      KIND_ICMP: zp.pos = 4'd1;
      KIND_IGMP: zp.pos = 4'd1;
      KIND_TCP:  zp.pos = 4'd8;
      KIND_UDP:  zp.pos = 4'd3;
      default: begin
        zp.hit = 1'b0;
        zp.pos = '0;
      end
    endcase
    return zp;
  endfunction

  function automatic logic has_pseudo(input kind_t kind);
    return kind inside {KIND_TCP, KIND_UDP};
  endfunction

  // end-around fold of a wide integer sum back to 16 bits
  function automatic word_t oc_fold(input logic [SumW-1:0] total);
    logic [WordW:0] f1;
    logic [WordW:0] f2;
    f1 = {1'b0, total[WordW-1:0]} + (WordW+1)'(total[SumW-1:WordW]);
    f2 = {1'b0, f1[WordW-1:0]} + (WordW+1)'(f1[WordW]);
    return f2[WordW-1:0];
  endfunction

endpackage

FILE: hw/rtl/internet_checksum_pseudo_header.sv
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header
// Ones-complement Internet checksum over a packet streamed as 16-bit words,
// with checksum-field zeroing and the TCP/UDP pseudo-header.
//
//  channel  dir  beat                     fields (low bit up)
//  s_*      in   one packet word          tdata: data_word, source_address,
//                                          dest_address; tuser: packet_kind,
//                                          odd_tail; tlast: last_word
//  m_*      out  one checksum per packet  tdata: checksum
//
// One beat per cycle sustained while no last beat stalls; the checksum is
// loaded as the last beat leaves the beat register, which feeds one adder
// tree with end-around fold into the running sum and the result register.
// Input stalls only while a last beat waits for a full result register.
// Synchronous reset clears the beat and result valid bits and packet state.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header
  import icph_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [icph_pkg::InDataW-1:0]   s_tdata,   // data_word, source_address, dest_address
  input  logic [icph_pkg::InUserW-1:0]   s_tuser,   // packet_kind, odd_tail
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [icph_pkg::OutDataW-1:0]  m_tdata    // checksum
);

  // beat register
  logic              a_valid;
  kind_t             a_kind;
  word_t             a_word;
  logic              a_last;
  logic              a_odd;
  logic [AddrW-1:0]  a_src;
  logic [AddrW-1:0]  a_dst;

  // packet state
  word_t             running_sum;
  word_t             segment_bytes;
  pos_t              word_position;
  kind_t             latched_kind;
  logic              mid_packet;

  logic              out_free;
  logic              advance;

  kind_t             kind_eff;
  pos_t              pos_eff;
  zero_pos_t         zp;
  logic              tail;
  word_t             word_eff;
  word_t             proto;
  word_t             seg_next;
  logic              first_pseudo;
  logic              add_len;
  logic [SumW-1:0]   total;
  word_t             sum_next;
  logic              m_tvalid_next;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = a_valid && (!a_last || out_free);
  assign s_tready = !a_valid || advance;

  always_comb begin
    kind_eff     = mid_packet ? latched_kind : a_kind;
    pos_eff      = mid_packet ? word_position : '0;
    zp           = zero_position(kind_eff);
    tail         = a_last && a_odd;
    word_eff     = tail ? {a_word[WordW-1:8], 8'h00} : a_word;
    if (zp.hit && (zp.pos == pos_eff)) begin
      word_eff = '0;
    end
    proto        = (a_kind == KIND_TCP) ? PROTO_TCP : PROTO_UDP;
    seg_next     = (mid_packet ? segment_bytes : '0) + (tail ? 16'd1 : 16'd2);
    first_pseudo = !mid_packet && has_pseudo(a_kind);
    add_len      = a_last && has_pseudo(kind_eff);
    total        = SumW'(word_eff)
                 + SumW'(mid_packet ? running_sum : '0)
                 + SumW'(add_len ? seg_next : '0)
                 + (first_pseudo ? (SumW'(a_src[31:16]) + SumW'(a_src[15:0])
                                  + SumW'(a_dst[31:16]) + SumW'(a_dst[15:0])
                                  + SumW'(proto)) : '0);
    sum_next     = oc_fold(total);
    if (advance && a_last) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      a_word <= s_tdata[15:0];
      a_src  <= s_tdata[47:16];
      a_dst  <= s_tdata[79:48];
      a_kind <= s_tuser[2:0];
      a_odd  <= s_tuser[3];
      a_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      segment_bytes <= '0;
      word_position <= '0;
      latched_kind  <= '0;
      mid_packet    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
      if (advance) begin
        running_sum   <= sum_next;
        segment_bytes <= seg_next;
        word_position <= (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 4'd1;
        latched_kind  <= kind_eff;
        mid_packet    <= !a_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_last) begin
      m_tdata <= ~sum_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    advance && a_last |=> !mid_packet)
    else $error("packet still open after last beat");

  a_mid_opens: assert property (@(posedge clk) disable iff (rst)
    advance && !a_last |=> mid_packet)
    else $error("packet not open after inner beat");

  a_inner_flows: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_last |-> advance)
    else $error("inner beat stalled");

  a_beat_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !advance |=> a_valid && $stable(a_word) && $stable(a_last))
    else $error("held beat changed");
`endif

endmodule
